// File: rtl/core/bsft_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsft_pkg
// Shared widths, register indexes, reset values and the fade arithmetic of
// the bouncing scanner with a fading trail.
// ----------------------------------------------------------------------------
package bsft_pkg;

   localparam int LED_COUNT_DEFAULT = 16;

   localparam int PIXEL_INDEX_W = 6;
   localparam int CHAN_W        = 8;
   localparam int PIXEL_W       = 3 * CHAN_W;
   localparam int FADE_W        = 9;
   localparam int STEPS_W       = 5;
   localparam int CSR_ADDR_W    = 3;
   localparam int CSR_DATA_W    = 9;

   // Register indexes on the configuration port.
   localparam logic [CSR_ADDR_W-1:0] REG_FADE_FACTOR    = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_STEPS_PER_TICK = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_COLOR_RED      = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_COLOR_GREEN    = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_COLOR_BLUE     = 3'd4;

   // Reset values; a fade of 179 is roughly 0.7 in Q1.8.
   localparam logic [FADE_W-1:0]  FADE_FACTOR_RESET    = 9'd179;
   localparam logic [STEPS_W-1:0] STEPS_PER_TICK_RESET = 5'd1;
   localparam logic [CHAN_W-1:0]  COLOR_RED_RESET      = 8'd255;
   localparam logic [CHAN_W-1:0]  COLOR_GREEN_RESET    = 8'd0;
   localparam logic [CHAN_W-1:0]  COLOR_BLUE_RESET     = 8'd0;

   // One colour channel times the Q1.8 factor, truncated and saturated.
   function automatic logic [CHAN_W-1:0] fade_chan(input logic [CHAN_W-1:0] value,
                                                   input logic [FADE_W-1:0] factor);
      logic [CHAN_W+FADE_W-1:0] prod;
      prod = {{FADE_W{1'b0}}, value} * {{CHAN_W{1'b0}}, factor};
      if (prod[CHAN_W+FADE_W-1]) begin
         fade_chan = {CHAN_W{1'b1}};
      end else begin
         fade_chan = prod[CHAN_W+FADE_W-2:CHAN_W];
      end
   endfunction

endpackage

// File: rtl/core/bsft_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsft_ram
// Generic single-clock RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module bsft_ram #(
   parameter int WIDTH  = 24,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/bouncing_scanner_fade_trail.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bouncing_scanner_fade_trail
// Bouncing LED scanner whose trail fades on every step; streams the strip.
// ----------------------------------------------------------------------------
// Usage: each transfer on the req_ channel is one command. With req_restart
// low it is a tick: the head moves steps_per_tick places, bouncing at both
// ends of the strip, and on every step all stored pixels are scaled by the
// Q1.8 fade factor before the head pixel is painted with the configured
// colour. With req_restart high the head returns to pixel 0, moving up, and
// pixel 0 is painted. Either way the whole strip is then streamed on the rsp_
// channel as LED_COUNT transfers in index order, the last one flagged.
// Sequence: a step is a head update followed by one read-modify-write sweep
// of the pixel RAM at one pixel a cycle; streaming reads every pixel
// through the RAM's registered port, in a fetch state and then a load state.
// A new command is taken once the final pixel sits in the output register.
// A stalled receiver simply holds the stream. Reset clears the pixels (via
// per-entry valid bits, no clearing pass), the head and the registers.
// The user writes csr_ registers only while idle; the block does not check.
// ----------------------------------------------------------------------------
module bouncing_scanner_fade_trail #(
   parameter int LED_COUNT = bsft_pkg::LED_COUNT_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   // Command channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_restart,
   // Pixel stream
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [bsft_pkg::PIXEL_INDEX_W-1:0]  rsp_pixel_index,
   output logic [bsft_pkg::CHAN_W-1:0]         rsp_red,
   output logic [bsft_pkg::CHAN_W-1:0]         rsp_green,
   output logic [bsft_pkg::CHAN_W-1:0]         rsp_blue,
   output logic                                rsp_last_pixel,
   // Configuration writes
   input  logic                                csr_wr_en,
   input  logic [bsft_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [bsft_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int IDX_W = $clog2(LED_COUNT);
   localparam int CNT_W = $clog2(LED_COUNT + 1);

   localparam logic [IDX_W-1:0] IDX_LAST   = IDX_W'(LED_COUNT - 1);
   localparam logic [IDX_W-1:0] IDX_BOUNCE = IDX_W'(LED_COUNT - 2);
   localparam logic [CNT_W-1:0] CNT_FULL   = CNT_W'(LED_COUNT);
   localparam logic [CNT_W-1:0] CNT_LAST   = CNT_W'(LED_COUNT - 1);

   typedef enum logic [4:0] {
      ST_IDLE    = 5'b00001,
      ST_STEP    = 5'b00010,
      ST_FADE    = 5'b00100,
      ST_EMIT_RD = 5'b01000,
      ST_EMIT_LD = 5'b10000
   } state_type;

   // Configuration registers.
   logic [bsft_pkg::FADE_W-1:0]  fade_factor_ff;
   logic [bsft_pkg::STEPS_W-1:0] steps_per_tick_ff;
   logic [bsft_pkg::CHAN_W-1:0]  color_red_ff, color_green_ff, color_blue_ff;

   // Sequencer state.
   state_type                    state_ff, state_in;
   logic [CNT_W-1:0]             cnt_ff, cnt_in;
   logic [bsft_pkg::STEPS_W-1:0] steps_left_ff, steps_left_in;
   logic [IDX_W-1:0]             head_ff, head_in;
   logic                         moving_down_ff, moving_down_in;
   logic [LED_COUNT-1:0]         valid_ff, valid_in;
   logic                         rd_valid_ff;

   // Output register.
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [bsft_pkg::PIXEL_INDEX_W-1:0] rsp_pixel_index_ff;
   logic [bsft_pkg::PIXEL_W-1:0]       rsp_pixel_ff;
   logic                               rsp_last_ff;

   // RAM ports.
   logic                         ram_wr_en;
   logic [IDX_W-1:0]             ram_wr_addr;
   logic [bsft_pkg::PIXEL_W-1:0] ram_wr_data;
   logic                         ram_rd_en;
   logic [IDX_W-1:0]             ram_rd_addr;
   logic [bsft_pkg::PIXEL_W-1:0] ram_rd_data;

   logic                         req_xfer;
   logic                         out_free;
   logic [IDX_W-1:0]             cnt_idx;
   logic [IDX_W-1:0]             sweep_wr_idx;
   logic [bsft_pkg::PIXEL_W-1:0] pixel_rd;
   logic [bsft_pkg::PIXEL_W-1:0] pixel_faded;
   logic [bsft_pkg::PIXEL_W-1:0] head_colour;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign cnt_idx      = cnt_ff[IDX_W-1:0];
   assign sweep_wr_idx = IDX_W'(cnt_ff - CNT_W'(1));
   assign head_colour  = {color_red_ff, color_green_ff, color_blue_ff};

   // Entries never written since reset read as black.
   assign pixel_rd = rd_valid_ff ? ram_rd_data : '0;

   assign pixel_faded = {
      bsft_pkg::fade_chan(pixel_rd[3*bsft_pkg::CHAN_W-1:2*bsft_pkg::CHAN_W],
                          fade_factor_ff),
      bsft_pkg::fade_chan(pixel_rd[2*bsft_pkg::CHAN_W-1:bsft_pkg::CHAN_W],
                          fade_factor_ff),
      bsft_pkg::fade_chan(pixel_rd[bsft_pkg::CHAN_W-1:0], fade_factor_ff)
   };

   // Configuration port.
   always_ff @(posedge clock) begin
      if (reset) begin
         fade_factor_ff    <= bsft_pkg::FADE_FACTOR_RESET;
         steps_per_tick_ff <= bsft_pkg::STEPS_PER_TICK_RESET;
         color_red_ff      <= bsft_pkg::COLOR_RED_RESET;
         color_green_ff    <= bsft_pkg::COLOR_GREEN_RESET;
         color_blue_ff     <= bsft_pkg::COLOR_BLUE_RESET;
      end else if (csr_wr_en) begin
         case (csr_addr)
            bsft_pkg::REG_FADE_FACTOR: begin
               fade_factor_ff <= csr_wdata;
            end
            bsft_pkg::REG_STEPS_PER_TICK: begin
               steps_per_tick_ff <= csr_wdata[bsft_pkg::STEPS_W-1:0];
            end
            bsft_pkg::REG_COLOR_RED: begin
               color_red_ff <= csr_wdata[bsft_pkg::CHAN_W-1:0];
            end
            bsft_pkg::REG_COLOR_GREEN: begin
               color_green_ff <= csr_wdata[bsft_pkg::CHAN_W-1:0];
            end
            bsft_pkg::REG_COLOR_BLUE: begin
               color_blue_ff <= csr_wdata[bsft_pkg::CHAN_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Sequencer. A step sweeps the RAM: the read of pixel cnt overlaps the
   // write-back of pixel cnt-1, so the two never touch the same entry.
   always_comb begin
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      steps_left_in  = steps_left_ff;
      head_in        = head_ff;
      moving_down_in = moving_down_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = sweep_wr_idx;
      ram_wr_data    = pixel_faded;
      ram_rd_en      = 1'b0;
      ram_rd_addr    = cnt_idx;

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               cnt_in = '0;
               if (req_restart) begin
                  // Restart paints pixel 0 straight away and streams.
                  head_in        = '0;
                  moving_down_in = 1'b0;
                  ram_wr_en      = 1'b1;
                  ram_wr_addr    = '0;
                  ram_wr_data    = head_colour;
                  state_in       = ST_EMIT_RD;
               end else if (steps_per_tick_ff == '0) begin
                  state_in = ST_EMIT_RD;
               end else begin
                  steps_left_in = steps_per_tick_ff;
                  state_in      = ST_STEP;
               end
            end
         end
         ST_STEP: begin
            // Move the head one place, bouncing at both ends.
            if (moving_down_ff) begin
               if (head_ff == '0) begin
                  head_in        = IDX_W'(1);
                  moving_down_in = 1'b0;
               end else begin
                  head_in = head_ff - IDX_W'(1);
               end
            end else if (head_ff == IDX_LAST) begin
               head_in        = IDX_BOUNCE;
               moving_down_in = 1'b1;
            end else begin
               head_in = head_ff + IDX_W'(1);
            end
            cnt_in   = '0;
            state_in = ST_FADE;
         end
         ST_FADE: begin
            ram_rd_en = (cnt_ff != CNT_FULL);
            if (cnt_ff != '0) begin
               ram_wr_en = 1'b1;
               if (sweep_wr_idx == head_ff) begin
                  ram_wr_data = head_colour;
               end
            end
            if (cnt_ff == CNT_FULL) begin
               cnt_in        = '0;
               steps_left_in = steps_left_ff - bsft_pkg::STEPS_W'(1);
               if (steps_left_ff == bsft_pkg::STEPS_W'(1)) begin
                  state_in = ST_EMIT_RD;
               end else begin
                  state_in = ST_STEP;
               end
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_EMIT_RD: begin
            // Fetch the next pixel only when the output register will be
            // free to take it in the following cycle.
            if (out_free) begin
               ram_rd_en = 1'b1;
               state_in  = ST_EMIT_LD;
            end
         end
         ST_EMIT_LD: begin
            rsp_valid_in = 1'b1;
            if (cnt_ff == CNT_LAST) begin
               state_in = ST_IDLE;
            end else begin
               cnt_in   = cnt_ff + CNT_W'(1);
               state_in = ST_EMIT_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      if (ram_wr_en) begin
         valid_in[ram_wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         cnt_ff         <= '0;
         steps_left_ff  <= '0;
         head_ff        <= '0;
         moving_down_ff <= 1'b0;
         valid_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
         rd_valid_ff    <= 1'b0;
      end else begin
         state_ff       <= state_in;
         cnt_ff         <= cnt_in;
         steps_left_ff  <= steps_left_in;
         head_ff        <= head_in;
         moving_down_ff <= moving_down_in;
         valid_ff       <= valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (ram_rd_en) begin
            rd_valid_ff <= valid_ff[ram_rd_addr];
         end
      end
   end

   // Output payload, loaded with the pixel fetched in the previous cycle.
   always_ff @(posedge clock) begin
      if (state_ff == ST_EMIT_LD) begin
         rsp_pixel_index_ff <= bsft_pkg::PIXEL_INDEX_W'(cnt_idx);
         rsp_pixel_ff       <= pixel_rd;
         rsp_last_ff        <= (cnt_ff == CNT_LAST);
      end
   end

   bsft_ram #(
      .WIDTH (bsft_pkg::PIXEL_W),
      .DEPTH (LED_COUNT)
   ) u_pixel_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_index = rsp_pixel_index_ff;
   assign rsp_red         = rsp_pixel_ff[3*bsft_pkg::CHAN_W-1:2*bsft_pkg::CHAN_W];
   assign rsp_green       = rsp_pixel_ff[2*bsft_pkg::CHAN_W-1:bsft_pkg::CHAN_W];
   assign rsp_blue        = rsp_pixel_ff[bsft_pkg::CHAN_W-1:0];
   assign rsp_last_pixel  = rsp_last_ff;

   // The head never leaves the strip.
   assert property (@(posedge clock) disable iff (reset)
      head_ff <= IDX_LAST)
      else $error("head position beyond the strip");

   // A restart transfer lands the head on pixel 0, moving up, ready to stream.
   assert property (@(posedge clock) disable iff (reset)
      req_xfer && req_restart |=> head_ff == '0 && !moving_down_ff &&
                                  state_ff == ST_EMIT_RD)
      else $error("restart did not reinitialise the head");

   // A pixel is only loaded into an output register that is free.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT_LD |-> !rsp_valid_ff)
      else $error("pixel loaded over a pending output");

   // The sweep never writes beyond the strip.
   assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> ram_wr_addr <= IDX_LAST)
      else $error("pixel RAM write out of range");

endmodule
